// ===== src/ssp_pkg.sv =====
// ssp_pkg: shared types, register indexes and reset constants for the servo switch press controller
// no dependencies; imported by every module of the block
package ssp_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int PERIOD_W       = 16;
    localparam int LIGHT_W        = 10;
    localparam int TIME_W         = 12;
    localparam int ANGLE_W        = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_WINTER_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MONITOR_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_TIME    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TIME      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_TIME      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_ANGLE     = 3'd6;

    localparam logic [PERIOD_W-1:0] MONITOR_PERIOD_RST  = 16'd1000;
    localparam logic [LIGHT_W-1:0]  LIGHT_THRESHOLD_RST = 10'd1000;
    localparam logic [TIME_W-1:0]   LOCKOUT_TIME_RST    = 12'd250;
    localparam logic [TIME_W-1:0]   PRESS_TIME_RST      = 12'd500;
    localparam logic [TIME_W-1:0]   CYCLE_TIME_RST      = 12'd1000;
    localparam logic [ANGLE_W-1:0]  PRESS_ANGLE_RST     = 8'd35;
    localparam logic [ANGLE_W-1:0]  MAX_ANGLE           = 8'd180;

    typedef struct packed {
        logic                winter_mode;
        logic [PERIOD_W-1:0] monitor_period;
        logic [LIGHT_W-1:0]  light_threshold;
        logic [TIME_W-1:0]   lockout_time;
        logic [TIME_W-1:0]   press_time;
        logic [TIME_W-1:0]   cycle_time;
        logic [ANGLE_W-1:0]  press_angle;
    } cfg_t;

    typedef struct packed {
        logic               button_level;
        logic [LIGHT_W-1:0] light_level;
        logic               toggle_request;
        logic               ack_change;
    } in_t;

    typedef struct packed {
        logic button_prev;
        logic pressing;
        logic toggle_pending;
        logic status_before_press;
        logic status_now;
        logic status_prev;
        logic change_flag;
        logic error_flag;
        logic led_state;
        logic servo_pressed;
        logic user_select;
    } flags_t;

    typedef struct packed {
        logic               heating_on;
        logic               led_on;
        logic [ANGLE_W-1:0] servo_angle;
        logic               toggle_error;
        logic               status_changed;
        logic               user_choice;
        logic               toggle_busy;
    } res_t;

endpackage

// ===== src/ssp_cfg.sv =====
// ssp_cfg: configuration register file written through the plain write port
// depends on ssp_pkg
module ssp_cfg
    import ssp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg,
    output logic                   select_clear
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next     = cfg_reg;
        select_clear = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINTER_MODE:
                begin
                    cfg_next.winter_mode = cfg_data[0];
                    select_clear         = !cfg_data[0];
                end
                REG_MONITOR_PERIOD:  cfg_next.monitor_period  = cfg_data[PERIOD_W-1:0];
                REG_LIGHT_THRESHOLD: cfg_next.light_threshold = cfg_data[LIGHT_W-1:0];
                REG_LOCKOUT_TIME:    cfg_next.lockout_time    = cfg_data[TIME_W-1:0];
                REG_PRESS_TIME:      cfg_next.press_time      = cfg_data[TIME_W-1:0];
                REG_CYCLE_TIME:      cfg_next.cycle_time      = cfg_data[TIME_W-1:0];
                REG_PRESS_ANGLE:     cfg_next.press_angle     = cfg_data[ANGLE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.winter_mode     <= 1'b0;
            cfg_reg.monitor_period  <= MONITOR_PERIOD_RST;
            cfg_reg.light_threshold <= LIGHT_THRESHOLD_RST;
            cfg_reg.lockout_time    <= LOCKOUT_TIME_RST;
            cfg_reg.press_time      <= PRESS_TIME_RST;
            cfg_reg.cycle_time      <= CYCLE_TIME_RST;
            cfg_reg.press_angle     <= PRESS_ANGLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/ssp_step.sv =====
// ssp_step: one tick of the controller as combinational logic, next state and result
// depends on ssp_pkg
module ssp_step
    import ssp_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  cfg_t                  cfg,
    input  in_t                   item,
    input  flags_t                flags,
    input  logic [TIMER_BITS-1:0] since_sample,
    input  logic [TIMER_BITS-1:0] since_button,
    input  logic [TIMER_BITS-1:0] since_press,
    output flags_t                flags_out,
    output logic [TIMER_BITS-1:0] since_sample_out,
    output logic [TIMER_BITS-1:0] since_button_out,
    output logic [TIMER_BITS-1:0] since_press_out,
    output res_t                  res
);

    localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

    always_comb
    begin
        flags_t                f;
        logic [TIMER_BITS-1:0] ss;
        logic [TIMER_BITS-1:0] sb;
        logic [TIMER_BITS-1:0] sp;
        logic                  lit;
        logic [ANGLE_W-1:0]    angle;

        f   = flags;
        lit = item.light_level > cfg.light_threshold;
        ss  = (since_sample == CNT_MAX) ? since_sample : since_sample + 1'b1;
        sb  = (since_button == CNT_MAX) ? since_button : since_button + 1'b1;
        sp  = (since_press  == CNT_MAX) ? since_press  : since_press  + 1'b1;

        // button edge past lockout in winter mode, then toggle request
        if (cfg.winter_mode && (item.button_level != f.button_prev)
            && (CMP_W'(sb) >= CMP_W'(cfg.lockout_time)))
        begin
            f.button_prev = item.button_level;
            sb            = '0;
            if (item.button_level)
            begin
                f.user_select    = !lit;
                f.toggle_pending = 1'b1;
            end
        end
        if (item.toggle_request)
        begin
            f.toggle_pending = 1'b1;
        end

        // press start, then release window
        if (f.toggle_pending)
        begin
            if ((CMP_W'(sp) > CMP_W'(cfg.cycle_time)) && !f.pressing)
            begin
                sp                    = '0;
                f.status_now          = lit;
                f.status_before_press = lit;
                f.servo_pressed       = 1'b1;
                f.pressing            = 1'b1;
            end
            if ((CMP_W'(sp) >= CMP_W'(cfg.press_time))
                && (CMP_W'(sp) < CMP_W'(cfg.cycle_time)))
            begin
                f.servo_pressed  = 1'b0;
                f.status_now     = lit;
                f.led_state      = lit;
                f.error_flag     = (lit == f.status_before_press);
                f.change_flag    = 1'b1;
                f.status_prev    = lit;
                f.pressing       = 1'b0;
                f.toggle_pending = 1'b0;
            end
        end

        // periodic sample
        if (CMP_W'(ss) >= CMP_W'(cfg.monitor_period))
        begin
            ss           = '0;
            f.status_now = lit;
            if (cfg.winter_mode)
            begin
                f.led_state = lit;
            end
            f.change_flag = (lit != f.status_prev);
            f.status_prev = lit;
            if (f.change_flag)
            begin
                f.error_flag = 1'b0;
            end
        end

        angle = (cfg.press_angle > MAX_ANGLE) ? MAX_ANGLE : cfg.press_angle;

        res.heating_on     = f.status_now;
        res.led_on         = f.led_state;
        res.servo_angle    = f.servo_pressed ? angle : '0;
        res.toggle_error   = f.error_flag;
        res.status_changed = f.change_flag;
        res.user_choice    = f.user_select;
        res.toggle_busy    = f.toggle_pending;

        if (item.ack_change)
        begin
            f.change_flag = 1'b0;
        end

        flags_out        = f;
        since_sample_out = ss;
        since_button_out = sb;
        since_press_out  = sp;
    end

endmodule

// ===== src/servo_switch_press_controller.sv =====
// servo_switch_press_controller: top level, input register, tick state and result register
// depends on ssp_pkg, ssp_cfg and ssp_step
// path: an accepted request goes through the input register, then the result register
// throughput: one request per cycle when out_stall is low, single tick step between registers
// reset clears all tick state and timers and loads the configuration defaults
module servo_switch_press_controller
    import ssp_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   button_level,
    input  logic [LIGHT_W-1:0]     light_level,
    input  logic                   toggle_request,
    input  logic                   ack_change,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   heating_on,
    output logic                   led_on,
    output logic [ANGLE_W-1:0]     servo_angle,
    output logic                   toggle_error,
    output logic                   status_changed,
    output logic                   user_choice,
    output logic                   toggle_busy
);

    cfg_t                  cfg;
    logic                  select_clear;
    logic                  in_valid_reg;
    in_t                   item_reg;
    logic                  out_valid_reg;
    res_t                  res_reg;
    res_t                  res_next;
    flags_t                flags_reg;
    flags_t                flags_next;
    logic [TIMER_BITS-1:0] since_sample_reg;
    logic [TIMER_BITS-1:0] since_sample_next;
    logic [TIMER_BITS-1:0] since_button_reg;
    logic [TIMER_BITS-1:0] since_button_next;
    logic [TIMER_BITS-1:0] since_press_reg;
    logic [TIMER_BITS-1:0] since_press_next;
    logic                  step_move;
    logic                  step_fire;

    ssp_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .select_clear (select_clear)
    );

    ssp_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step
    (
        .cfg              (cfg),
        .item             (item_reg),
        .flags            (flags_reg),
        .since_sample     (since_sample_reg),
        .since_button     (since_button_reg),
        .since_press      (since_press_reg),
        .flags_out        (flags_next),
        .since_sample_out (since_sample_next),
        .since_button_out (since_button_next),
        .since_press_out  (since_press_next),
        .res              (res_next)
    );

    assign step_move = !out_valid_reg || !out_stall;
    assign step_fire = in_valid_reg && step_move;
    assign in_stall  = in_valid_reg && !step_move;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.button_level   <= button_level;
            item_reg.light_level    <= light_level;
            item_reg.toggle_request <= toggle_request;
            item_reg.ack_change     <= ack_change;
        end
    end

    // tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg        <= '0;
            since_sample_reg <= '0;
            since_button_reg <= '0;
            since_press_reg  <= '0;
        end
        else if (step_fire)
        begin
            flags_reg        <= flags_next;
            since_sample_reg <= since_sample_next;
            since_button_reg <= since_button_next;
            since_press_reg  <= since_press_next;
        end
        else if (select_clear)
        begin
            flags_reg.user_select <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_move)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign heating_on     = res_reg.heating_on;
    assign led_on         = res_reg.led_on;
    assign servo_angle    = res_reg.servo_angle;
    assign toggle_error   = res_reg.toggle_error;
    assign status_changed = res_reg.status_changed;
    assign user_choice    = res_reg.user_choice;
    assign toggle_busy    = res_reg.toggle_busy;

    // servo drive and press phase move together
    a_servo_follows_press: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.servo_pressed == flags_reg.pressing)
        else $error("servo drive and press phase disagree");

    // a press only runs while a toggle is pending
    a_press_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.pressing |-> flags_reg.toggle_pending)
        else $error("press running with no pending toggle");

    // a held request in the input register waits for the result register
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |=> in_valid_reg)
        else $error("request lost while result stalled");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.servo_angle <= MAX_ANGLE))
        else $error("servo angle out of range");

endmodule

// ===== dv/ssp_tick_checker.sv =====
// ssp_tick_checker: watches the request, result and register ports of the servo switch press
// controller, predicts every result from its own copy of the tick state and compares it
// depends on ssp_pkg
module ssp_tick_checker
    import ssp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   button_level,
    input  logic [LIGHT_W-1:0]     light_level,
    input  logic                   toggle_request,
    input  logic                   ack_change,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   heating_on,
    input  logic                   led_on,
    input  logic [ANGLE_W-1:0]     servo_angle,
    input  logic                   toggle_error,
    input  logic                   status_changed,
    input  logic                   user_choice,
    input  logic                   toggle_busy,
    output int unsigned            due_count,
    output int unsigned            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_W     = TIMER_BITS_DEF;

    cfg_t              regs;
    flags_t            st;
    logic [TICK_W-1:0] since_sample;
    logic [TICK_W-1:0] since_button;
    logic [TICK_W-1:0] since_press;
    res_t              due_status[$];
    int unsigned       mismatches = 0;
    int unsigned       result_no = 0;

    assign fail_count = mismatches;

    function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%t checker: %s", $realtime, msg);
    endtask

    task automatic check_field(input string what, input logic [ANGLE_W-1:0] got,
                               input logic [ANGLE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_no, what, got, want));
    endtask

    task automatic load_defaults;
        regs.winter_mode     = 1'b0;
        regs.monitor_period  = MONITOR_PERIOD_RST;
        regs.light_threshold = LIGHT_THRESHOLD_RST;
        regs.lockout_time    = LOCKOUT_TIME_RST;
        regs.press_time      = PRESS_TIME_RST;
        regs.cycle_time      = CYCLE_TIME_RST;
        regs.press_angle     = PRESS_ANGLE_RST;
        st           = '0;
        since_sample = '0;
        since_button = '0;
        since_press  = '0;
        due_status.delete();
    endtask

    task automatic shadow_write(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINTER_MODE:
            begin
                regs.winter_mode = data[0];
                if (!data[0])
                    st.user_select = 1'b0;
            end
            REG_MONITOR_PERIOD:  regs.monitor_period  = data[PERIOD_W-1:0];
            REG_LIGHT_THRESHOLD: regs.light_threshold = data[LIGHT_W-1:0];
            REG_LOCKOUT_TIME:    regs.lockout_time    = data[TIME_W-1:0];
            REG_PRESS_TIME:      regs.press_time      = data[TIME_W-1:0];
            REG_CYCLE_TIME:      regs.cycle_time      = data[TIME_W-1:0];
            REG_PRESS_ANGLE:     regs.press_angle     = data[ANGLE_W-1:0];
            default: ;
        endcase
    endtask

    // one millisecond tick: button, toggle press/release, periodic sample, then ack clear
    function automatic res_t ms_tick(input in_t t);
        res_t               r;
        logic               lit;
        logic [ANGLE_W-1:0] angle;
        lit = t.light_level > regs.light_threshold;
        since_sample = bump(since_sample);
        since_button = bump(since_button);
        since_press  = bump(since_press);

        if (regs.winter_mode && t.button_level != st.button_prev
                && since_button >= regs.lockout_time)
        begin
            st.button_prev = t.button_level;
            since_button   = '0;
            if (t.button_level)
            begin
                st.user_select    = !lit;
                st.toggle_pending = 1'b1;
            end
        end
        if (t.toggle_request)
            st.toggle_pending = 1'b1;

        if (st.toggle_pending)
        begin
            if (since_press > regs.cycle_time && !st.pressing)
            begin
                since_press            = '0;
                st.status_now          = lit;
                st.status_before_press = lit;
                st.servo_pressed       = 1'b1;
                st.pressing            = 1'b1;
            end
            // release also runs when no press was started
            if (since_press >= regs.press_time && since_press < regs.cycle_time)
            begin
                st.servo_pressed  = 1'b0;
                st.status_now     = lit;
                st.led_state      = lit;
                st.error_flag     = (st.status_now == st.status_before_press);
                st.change_flag    = 1'b1;
                st.status_prev    = st.status_now;
                st.pressing       = 1'b0;
                st.toggle_pending = 1'b0;
            end
        end

        if (since_sample >= regs.monitor_period)
        begin
            since_sample  = '0;
            st.status_now = lit;
            if (regs.winter_mode)
                st.led_state = lit;
            st.change_flag = (st.status_now != st.status_prev);
            st.status_prev = st.status_now;
            if (st.change_flag)
                st.error_flag = 1'b0;
        end

        angle = (regs.press_angle > MAX_ANGLE) ? MAX_ANGLE : regs.press_angle;
        r.heating_on     = st.status_now;
        r.led_on         = st.led_state;
        r.servo_angle    = st.servo_pressed ? angle : '0;
        r.toggle_error   = st.error_flag;
        r.status_changed = st.change_flag;
        r.user_choice    = st.user_select;
        r.toggle_busy    = st.toggle_pending;

        if (t.ack_change)
            st.change_flag = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        in_t  req;
        res_t want;
        if (!rst_n)
        begin
            load_defaults();
            due_count <= 0;
        end
        else
        begin
            if (cfg_we)
                shadow_write(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                req.button_level   = button_level;
                req.light_level    = light_level;
                req.toggle_request = toggle_request;
                req.ack_change     = ack_change;
                due_status.push_back(ms_tick(req));
            end
            if (out_valid && !out_stall)
            begin
                if (due_status.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing due", result_no));
                else
                begin
                    want = due_status.pop_front();
                    check_field("heating_on", ANGLE_W'(heating_on),
                                ANGLE_W'(want.heating_on));
                    check_field("led_on", ANGLE_W'(led_on), ANGLE_W'(want.led_on));
                    check_field("servo_angle", servo_angle, want.servo_angle);
                    check_field("toggle_error", ANGLE_W'(toggle_error),
                                ANGLE_W'(want.toggle_error));
                    check_field("status_changed", ANGLE_W'(status_changed),
                                ANGLE_W'(want.status_changed));
                    check_field("user_choice", ANGLE_W'(user_choice),
                                ANGLE_W'(want.user_choice));
                    check_field("toggle_busy", ANGLE_W'(toggle_busy),
                                ANGLE_W'(want.toggle_busy));
                end
                result_no++;
            end
            due_count <= due_status.size();
        end
    end

endmodule

// ===== dv/servo_switch_press_controller_tb.sv =====
// servo_switch_press_controller_tb: drives ticks and register writes into the controller with
// random gaps and stalls, and gives the verdict from the checker's mismatch count
// depends on ssp_pkg, ssp_tick_checker and the controller rtl
module servo_switch_press_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssp_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam int SETTLE      = 8;
    localparam int PHASES      = 9;
    localparam int PHASE_TICKS = 80;
    localparam int SOAK_TICKS  = 100;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   button_level;
    logic [LIGHT_W-1:0]     light_level;
    logic                   toggle_request;
    logic                   ack_change;
    logic                   out_valid;
    logic                   out_stall;
    logic                   heating_on;
    logic                   led_on;
    logic [ANGLE_W-1:0]     servo_angle;
    logic                   toggle_error;
    logic                   status_changed;
    logic                   user_choice;
    logic                   toggle_busy;
    int unsigned            due_count;
    int unsigned            fail_count;

    bit send_pace;
    bit sink_pace;
    bit heat_guess;
    bit btn_hold;
    int thr_now;

    servo_switch_press_controller u_top (.*);
    ssp_tick_checker u_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: stall for a drawn number of cycles, then take one result
    initial
    begin : sink
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            n = sink_pace ? $urandom_range(0, 9) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_tick(input logic b, input logic [LIGHT_W-1:0] light,
                             input logic req, input logic ack);
        int gap;
        gap = send_pace ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        button_level   <= b;
        light_level    <= light;
        toggle_request <= req;
        ack_change     <= ack;
        do @(posedge clk); while (in_stall);
    endtask

    // light mostly follows a slowly flipping heating state around the threshold
    task automatic random_tick(input bit with_req);
        logic [LIGHT_W-1:0] light;
        if ($urandom_range(0, 9) == 0)
            heat_guess = ~heat_guess;
        if ($urandom_range(0, 4) == 0)
            btn_hold = ~btn_hold;
        if ($urandom_range(0, 9) == 0)
            light = LIGHT_W'($urandom_range(0, 1023));
        else if (heat_guess && thr_now < 1023)
            light = LIGHT_W'($urandom_range(thr_now + 1, 1023));
        else
            light = LIGHT_W'($urandom_range(0, thr_now));
        send_tick(btn_hold, light, with_req && $urandom_range(0, 15) == 0,
                  $urandom_range(0, 2) == 0);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (due_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // upper bits beyond the register width are sometimes filled with noise
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value,
                             input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = '0;
        if ($urandom_range(0, 1))
            junk = CFG_DATA_W'($urandom) << width;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= junk | CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic program_regs(input int unsigned w, input int unsigned period,
                                input int unsigned thr, input int unsigned lock,
                                input int unsigned press, input int unsigned cyc,
                                input int unsigned angle);
        write_reg(REG_WINTER_MODE, w, 1);
        write_reg(REG_MONITOR_PERIOD, period, PERIOD_W);
        write_reg(REG_LIGHT_THRESHOLD, thr, LIGHT_W);
        write_reg(REG_LOCKOUT_TIME, lock, TIME_W);
        write_reg(REG_PRESS_TIME, press, TIME_W);
        write_reg(REG_CYCLE_TIME, cyc, TIME_W);
        write_reg(REG_PRESS_ANGLE, angle, ANGLE_W);
        write_reg(REG_SPARE, $urandom, CFG_DATA_W);
        cfg_we <= 1'b0;
        thr_now = thr;
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        button_level   <= 1'b0;
        light_level    <= '0;
        toggle_request <= 1'b0;
        ack_change     <= 1'b0;
        send_pace  = 1'b0;
        sink_pace  = 1'b1;
        heat_guess = 1'b0;
        btn_hold   = 1'b0;
        thr_now    = LIGHT_THRESHOLD_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short timers, oversized angle, button with request on one tick, release with no press
        program_regs(1, 3, 500, 0, 2, 4, 255);
        send_tick(1'b0, 10'd0,   1'b0, 1'b0);
        send_tick(1'b1, 10'h3FF, 1'b1, 1'b0);
        send_tick(1'b1, 10'h3FF, 1'b0, 1'b1);
        send_tick(1'b0, 10'd0,   1'b0, 1'b0);
        send_tick(1'b1, 10'd0,   1'b0, 1'b0);
        send_tick(1'b1, 10'd501, 1'b0, 1'b0);
        send_tick(1'b1, 10'd500, 1'b0, 1'b1);
        send_tick(1'b0, 10'd501, 1'b1, 1'b0);
        send_tick(1'b0, 10'h3FF, 1'b0, 1'b0);
        send_tick(1'b1, 10'd0,   1'b0, 1'b1);
        send_tick(1'b1, 10'd0,   1'b0, 1'b0);
        send_tick(1'b0, 10'h3FF, 1'b0, 1'b0);
        drain;

        // winter off clears the choice, every tick samples, press never releases
        send_pace = 1'b1;
        program_regs(0, 0, 0, 0, 0, 0, 181);
        send_tick(1'b1, 10'd0,   1'b1, 1'b0);
        send_tick(1'b0, 10'd1,   1'b0, 1'b0);
        send_tick(1'b1, 10'h3FF, 1'b1, 1'b1);
        send_tick(1'b0, 10'd0,   1'b1, 1'b0);
        send_tick(1'b1, 10'h3FF, 1'b0, 1'b1);
        send_tick(1'b0, 10'd0,   1'b0, 1'b0);
        drain;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: program_regs(0, 0, 0, 0, 0, 0, 0);
                1: program_regs(1, 65535, 1023, 4095, 4095, 4095, 255);
                2: program_regs(1, MONITOR_PERIOD_RST, LIGHT_THRESHOLD_RST, LOCKOUT_TIME_RST,
                                PRESS_TIME_RST, CYCLE_TIME_RST, PRESS_ANGLE_RST);
                default: program_regs($urandom_range(0, 1), $urandom_range(0, 12),
                                      $urandom_range(0, 1023), $urandom_range(0, 8),
                                      $urandom_range(0, 6), $urandom_range(0, 10),
                                      $urandom_range(0, 255));
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (n % 25 == 0)
                begin
                    send_pace = $urandom_range(0, 3) != 0;
                    sink_pace = $urandom_range(0, 3) != 0;
                end
                if (n == PHASE_TICKS / 2)
                    drain;
                random_tick(1'b1);
            end
            drain;
        end

        // quiet run with no requests, then presses from there
        program_regs(0, 65535, 500, 100, 3, 4095, 90);
        send_pace = 1'b0;
        sink_pace = 1'b0;
        repeat (SOAK_TICKS) random_tick(1'b0);
        for (int n = 0; n < 150; n++)
        begin
            if (n % 25 == 0)
            begin
                send_pace = $urandom_range(0, 3) != 0;
                sink_pace = $urandom_range(0, 3) != 0;
            end
            random_tick(1'b1);
        end
        drain;

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== servo_switch_press_controller.f =====
src/ssp_pkg.sv
src/ssp_cfg.sv
src/ssp_step.sv
src/servo_switch_press_controller.sv
dv/ssp_tick_checker.sv
dv/servo_switch_press_controller_tb.sv
